// ===== hdl/led_command_frame_controller_defines.svh =====
// ----------------------------------------------------------------------------
// LED command frame controller assertion macros
// Concurrent checks sampled on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef LED_COMMAND_FRAME_CONTROLLER_DEFINES_SVH
`define LED_COMMAND_FRAME_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF
`define LCFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LCFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LCFC_ASSERT_NOW(lbl, ante, cons, msg)
`define LCFC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/lcfc_pkg.sv =====
// ----------------------------------------------------------------------------
// LED command frame controller package
// Frame layout, command and response codes, and the job passed front to back.
// ----------------------------------------------------------------------------
package lcfc_pkg;

  localparam int FRAME_LEN   = 9;
  localparam int RESP_LEN    = 10;
  localparam int MODES       = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [3:0] POS_START  = 4'd0;
  localparam logic [3:0] POS_CMD    = 4'd1;
  localparam logic [3:0] POS_VALUE  = 4'd2;
  localparam logic [3:0] POS_RED    = 4'd3;
  localparam logic [3:0] POS_GREEN  = 4'd4;
  localparam logic [3:0] POS_BLUE   = 4'd5;
  localparam logic [3:0] POS_BRIGHT = 4'd6;
  localparam logic [3:0] POS_CSUM   = 4'd7;
  localparam logic [3:0] POS_END    = 4'd8;

  localparam logic [7:0] START_BYTE = 8'h01;
  localparam logic [7:0] END_BYTE   = 8'h01;
  localparam logic [7:0] CMD_MAX    = 8'd4;
  localparam logic [7:0] VALUE_MAX  = 8'd2;

  localparam logic [7:0] CMD_NOP   = 8'd0;
  localparam logic [7:0] CMD_SHOW  = 8'd1;
  localparam logic [7:0] CMD_CLEAR = 8'd2;
  localparam logic [7:0] CMD_MODE  = 8'd3;
  localparam logic [7:0] CMD_STORE = 8'd4;

  localparam logic [1:0] MODE_0 = 2'd0;
  localparam logic [1:0] MODE_1 = 2'd1;
  localparam logic [1:0] MODE_2 = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [3:0] IDX_FIRST = 4'd0;
  localparam logic [3:0] IDX_CODE  = 4'd1;
  localparam logic [3:0] IDX_LAST  = 4'(RESP_LEN - 1);

  localparam logic [7:0] RESP_MARK = 8'h01;

  typedef enum logic [2:0] {
    CODE_OK    = 3'd0,
    CODE_START = 3'd1,
    CODE_CMD   = 3'd2,
    CODE_VALUE = 3'd3,
    CODE_CSUM  = 3'd4,
    CODE_END   = 3'd5
  } resp_code_t;

  // colour packs red 7:0, green 15:8, blue 23:16, brightness 31:24
  typedef struct packed {
    logic        is_frame;
    resp_code_t  code;
    logic        led;
    logic [31:0] colour;
  } job_t;

endpackage

// ===== hdl/lcfc_front.sv =====
// ----------------------------------------------------------------------------
// LED command frame controller front end
// Collects frame bytes, runs the checks byte by byte, executes commands and
// button presses against mode and colour table, and issues one job per event.
// ----------------------------------------------------------------------------
module lcfc_front
  import lcfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] rx_byte,
  input  logic       full,
  output logic       push,
  output job_t       push_data
);

  logic [3:0]  pos;
  resp_code_t  code;
  resp_code_t  code_next;
  logic [7:0]  sum;
  logic [7:0]  sum_next;
  logic [7:0]  cmd;
  logic [7:0]  value;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  bright;
  logic [1:0]  mode;
  logic [1:0]  mode_inc;
  logic [31:0] colour_tbl [MODES];

  logic        in_fire;
  logic        byte_fire;
  logic        btn_fire;
  logic        frame_end;
  logic        exec_ok;
  logic [1:0]  rd_addr;
  logic [1:0]  wr_addr;
  logic [31:0] rd_colour;
  logic        frame_led;
  logic [31:0] frame_colour;

  assign in_stall  = full;
  assign in_fire   = in_valid && !full;
  assign byte_fire = in_fire && !kind;
  assign btn_fire  = in_fire && kind;
  assign frame_end = byte_fire && (pos == POS_END);
  assign exec_ok   = frame_end && (code_next == CODE_OK);

  always_comb begin
    case (mode)
      MODE_0:  mode_inc = MODE_1;
      MODE_1:  mode_inc = MODE_2;
      MODE_2:  mode_inc = MODE_0;
      default: mode_inc = MODE_1;
    endcase
  end

  assign rd_addr   = kind ? mode_inc : ((cmd == CMD_MODE) ? value[1:0] : mode);
  assign wr_addr   = (mode == MODE_NONE) ? MODE_0 : mode;
  assign rd_colour = (rd_addr == MODE_NONE) ? 32'd0 : colour_tbl[rd_addr];

  // run checks in frame order; the first failure sticks
  always_comb begin
    code_next = code;
    sum_next  = sum;
    case (pos)
      POS_START: begin
        code_next = (rx_byte == START_BYTE) ? CODE_OK : CODE_START;
        sum_next  = 8'd0;
      end
      POS_CMD: begin
        sum_next = sum + rx_byte;
        if (code == CODE_OK && rx_byte > CMD_MAX) code_next = CODE_CMD;
      end
      POS_VALUE: begin
        sum_next = sum + rx_byte;
        if (code == CODE_OK && rx_byte > VALUE_MAX) code_next = CODE_VALUE;
      end
      POS_RED, POS_GREEN, POS_BLUE, POS_BRIGHT: begin
        sum_next = sum + rx_byte;
      end
      POS_CSUM: begin
        if (code == CODE_OK && rx_byte != sum) code_next = CODE_CSUM;
      end
      POS_END: begin
        if (code == CODE_OK && rx_byte != END_BYTE) code_next = CODE_END;
      end
      default: ;
    endcase
  end

  always_comb begin
    frame_led    = 1'b0;
    frame_colour = 32'd0;
    if (code_next == CODE_OK) begin
      case (cmd)
        CMD_SHOW: begin
          frame_led    = 1'b1;
          frame_colour = rd_colour;
        end
        CMD_CLEAR: begin
          frame_led = 1'b1;
        end
        CMD_MODE: begin
          frame_led    = 1'b1;
          frame_colour = rd_colour;
        end
        default: ;
      endcase
    end
  end

  assign push               = btn_fire || frame_end;
  assign push_data.is_frame = !kind;
  assign push_data.code     = kind ? CODE_OK : code_next;
  assign push_data.led      = kind ? 1'b1 : frame_led;
  assign push_data.colour   = kind ? rd_colour : frame_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= POS_START;
      code       <= CODE_OK;
      mode       <= MODE_0;
      colour_tbl <= '{default: 32'd0};
    end else begin
      if (byte_fire) begin
        pos  <= frame_end ? POS_START : pos + 4'd1;
        code <= code_next;
        sum  <= sum_next;
        case (pos)
          POS_CMD:    cmd    <= rx_byte;
          POS_VALUE:  value  <= rx_byte;
          POS_RED:    red    <= rx_byte;
          POS_GREEN:  green  <= rx_byte;
          POS_BLUE:   blue   <= rx_byte;
          POS_BRIGHT: bright <= rx_byte;
          default: ;
        endcase
      end
      if (btn_fire) begin
        mode <= mode_inc;
      end
      if (exec_ok) begin
        case (cmd)
          CMD_MODE:  mode <= value[1:0];
          CMD_STORE: colour_tbl[wr_addr] <= {bright, blue, green, red};
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hdl/lcfc_queue.sv =====
// ----------------------------------------------------------------------------
// LED command frame controller job queue
// Small first-in first-out buffer of jobs between front and back ends.
// ----------------------------------------------------------------------------
module lcfc_queue
  import lcfc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== hdl/lcfc_back.sv =====
// ----------------------------------------------------------------------------
// LED command frame controller back end
// Expands each job into its result transfers: one for a button press, the
// ten-byte response for a frame with any display update on the first byte.
// ----------------------------------------------------------------------------
module lcfc_back
  import lcfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       empty,
  input  job_t       pop_data,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       led_valid,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [7:0] brightness,
  output logic       last
);

  logic       busy;
  job_t       job;
  logic [3:0] idx;
  logic       out_fire;
  logic       load;

  assign out_valid = busy;
  assign out_fire  = busy && !out_stall;
  assign load      = !busy || (out_fire && last);
  assign pop       = load && !empty;

  assign tx_valid  = job.is_frame;
  assign led_valid = job.led && (!job.is_frame || idx == IDX_FIRST);
  assign last      = !job.is_frame || idx == IDX_LAST;

  always_comb begin
    tx_byte = 8'd0;
    if (job.is_frame) begin
      if (idx == IDX_FIRST || idx == IDX_LAST) tx_byte = RESP_MARK;
      else if (idx == IDX_CODE) tx_byte = {5'd0, job.code};
    end
  end

  assign red        = led_valid ? job.colour[7:0]   : 8'd0;
  assign green      = led_valid ? job.colour[15:8]  : 8'd0;
  assign blue       = led_valid ? job.colour[23:16] : 8'd0;
  assign brightness = led_valid ? job.colour[31:24] : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= IDX_FIRST;
    end else if (load) begin
      busy <= !empty;
      idx  <= IDX_FIRST;
      if (!empty) job <= pop_data;
    end else if (out_fire) begin
      idx <= idx + 4'd1;
    end
  end

endmodule

// ===== hdl/led_command_frame_controller.sv =====
// ----------------------------------------------------------------------------
// LED command frame controller
// Gathers 9-byte command frames and button presses, drives the LED colour and
// answers every frame with a 10-byte response.
// ----------------------------------------------------------------------------
// channel | signals                                    | transfer when
// in      | in_valid in_stall kind rx_byte             | in_valid & !in_stall
// out     | out_valid out_stall tx_valid tx_byte       | out_valid & !out_stall
//         | led_valid red green blue brightness last   |
//
// An input is taken every cycle while the job queue has room.
// A frame drains as ten output transfers, a button press as one; the back end's
// response counter sets the output rate at one transfer per cycle unless stalled.
// Synchronous reset clears byte position, mode, colour table, queue and back end.
// out_stall holds the back end only; the front end runs until the queue fills.
// ----------------------------------------------------------------------------
`include "led_command_frame_controller_defines.svh"

module led_command_frame_controller
  import lcfc_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       led_valid,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [7:0] brightness,
  output logic       last
);

  logic q_push;
  job_t q_push_data;
  logic q_full;
  logic q_pop;
  job_t q_pop_data;
  logic q_empty;
  logic led_on_tx;
  logic out_done;

  lcfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .rx_byte   (rx_byte),
    .full      (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  lcfc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  lcfc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (q_empty),
    .pop_data   (q_pop_data),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tx_valid   (tx_valid),
    .tx_byte    (tx_byte),
    .led_valid  (led_valid),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .brightness (brightness),
    .last       (last)
  );

  assign led_on_tx = out_valid && led_valid && tx_valid;
  assign out_done  = out_valid && !out_stall && last;

  `LCFC_ASSERT_NOW(a_push_room, q_push, !q_full, "job pushed into full queue")
  `LCFC_ASSERT_NOW(a_led_on_first, led_on_tx, tx_byte == RESP_MARK, "update off first byte")
  `LCFC_ASSERT_NEXT(a_drain_idle, out_done && q_empty, !out_valid, "output with no job pending")

endmodule
